[rtl/relay_mask_command_controller_top_assert.svh]
// Assertion macros for the relay mask command controller.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef RELAY_MASK_COMMAND_CONTROLLER_TOP_ASSERT_SVH
`define RELAY_MASK_COMMAND_CONTROLLER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMCC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RMCC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rmcc_pkg.sv]
`default_nettype none

package rmcc_pkg;

    // Number of relay outputs that exist; ports beyond it are ignored
    localparam int OUTPUT_COUNT = 8;
    localparam int MASK_WIDTH   = 8;
    localparam int PORT_LIMIT   = (OUTPUT_COUNT < MASK_WIDTH) ? OUTPUT_COUNT : MASK_WIDTH;

    // Register reset values: one hour and fifteen seconds in 5 s ticks
    localparam logic [15:0] LONG_RESET_TICKS_RST = 16'd720;
    localparam logic [7:0]  SAVE_TICKS_RST       = 8'd3;

    // Configuration register indexes
    localparam logic CFG_LONG_RESET_TICKS = 1'b0;
    localparam logic CFG_SAVE_TICKS       = 1'b1;

    // Request kinds
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_SWITCH = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    // Command bytes (ASCII)
    localparam logic [7:0] CMD_SET_PORT    = 8'h73; // 's'
    localparam logic [7:0] CMD_LOAD_MASK   = 8'h53; // 'S'
    localparam logic [7:0] CMD_TOGGLE_PORT = 8'h74; // 't'
    localparam logic [7:0] CMD_ALL_OFF     = 8'h66; // 'f'
    localparam logic [7:0] CMD_ALL_ON      = 8'h6E; // 'n'
    localparam logic [7:0] CMD_GET_PORT    = 8'h67; // 'g'
    localparam logic [7:0] CMD_GET_MASK    = 8'h47; // 'G'

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] command;
        logic [7:0] data;
        logic [2:0] switch_number;
    } t_req;

    typedef struct packed {
        logic [7:0] relay_mask;
        logic [7:0] read_data;
        logic       irq_line;
        logic       save_request;
        logic       long_reset_request;
        logic       command_led;
    } t_rsp;

    // Timer events raised by one tick
    typedef struct packed {
        logic long_fire;
        logic save_fire;
    } t_tick_fire;

    // Mask bit of a 0-based port, zero when the port does not exist
    function automatic logic [7:0] port_bit(logic [7:0] port0);
        logic [7:0] bits;
        bits = 8'd0;
        if (port0 < 8'(PORT_LIMIT)) begin
            bits = 8'd1 << port0[2:0];
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

[rtl/rmcc_tick_timer.sv]
`default_nettype none

module rmcc_tick_timer (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_advance,
    input  wire logic [15:0]          i_long_limit,
    input  wire logic [7:0]           i_save_limit,
    output rmcc_pkg::t_tick_fire      o_fire
);

    logic [15:0] r_long_count;
    logic [15:0] n_long_count;
    logic [7:0]  r_save_count;
    logic [7:0]  n_save_count;
    logic [15:0] long_inc;
    logic [7:0]  save_inc;

    // On an advance, increment both counters; each fires and wraps to zero on a match with its limit
    always_comb begin
        long_inc     = r_long_count + 16'd1;
        save_inc     = r_save_count + 8'd1;
        o_fire       = '0;
        n_long_count = r_long_count;
        n_save_count = r_save_count;
        if (i_advance) begin
            if (long_inc == i_long_limit) begin
                o_fire.long_fire = 1'b1;
                n_long_count     = 16'd0;
            end else begin
                n_long_count = long_inc;
            end
            if (save_inc == i_save_limit) begin
                o_fire.save_fire = 1'b1;
                n_save_count     = 8'd0;
            end else begin
                n_save_count = save_inc;
            end
        end
    end

    // Hold counts between ticks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_count <= 16'd0;
            r_save_count <= 8'd0;
        end else begin
            r_long_count <= n_long_count;
            r_save_count <= n_save_count;
        end
    end

endmodule

`default_nettype wire

[rtl/relay_mask_command_controller_top.sv]
// Channel   Direction  Handshake                     Payload
// request   in         i_in_valid / o_in_ready       i_in_data  (rmcc_pkg::t_req)
// response  out        o_out_valid / i_out_ready     o_out_data (rmcc_pkg::t_rsp)
// config    in         i_cfg_wr_en                   i_cfg_index, i_cfg_wdata
//
// One request per cycle while the output is not stalled; its response appears
// in the output register in the cycle after acceptance. The state update and
// the decode of one request sit in a single combinational pass ahead of the
// response register. Synchronous active-low reset clears mask, flags, counters
// and loads the default tick limits. A new request is taken whenever the
// response register is empty or drained in the same cycle.
`default_nettype none

module relay_mask_command_controller_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output      logic            o_in_ready,
    input  wire rmcc_pkg::t_req  i_in_data,
    output      logic            o_out_valid,
    input  wire logic            i_out_ready,
    output      rmcc_pkg::t_rsp  o_out_data,
    input  wire logic            i_cfg_wr_en,
    input  wire logic            i_cfg_index,
    input  wire logic [15:0]     i_cfg_wdata
);

    logic [15:0]          r_long_limit;
    logic [7:0]           r_save_limit;
    logic [7:0]           r_mask;
    logic [7:0]           n_mask;
    logic                 r_save_pending;
    logic                 n_save_pending;
    logic                 r_irq;
    logic                 n_irq;
    logic                 r_out_valid;
    rmcc_pkg::t_rsp       r_out_data;
    rmcc_pkg::t_rsp       n_rsp;
    rmcc_pkg::t_tick_fire tick_fire;
    logic                 accept;
    logic                 tick_accept;
    logic [3:0]           set_port;
    logic [7:0]           set_bit;
    logic [7:0]           toggle_bit;
    logic                 write_accept;
    logic                 write_rsp_ok;
    logic                 tick_rsp_ok;
    logic                 read_rsp_seen;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign tick_accept = accept &&
                         (rmcc_pkg::t_op'(i_in_data.operation) == rmcc_pkg::OP_TICK);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Tick counters
    rmcc_tick_timer u_tick_timer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (tick_accept),
        .i_long_limit (r_long_limit),
        .i_save_limit (r_save_limit),
        .o_fire       (tick_fire)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_limit <= rmcc_pkg::LONG_RESET_TICKS_RST;
            r_save_limit <= rmcc_pkg::SAVE_TICKS_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == rmcc_pkg::CFG_LONG_RESET_TICKS) begin
                r_long_limit <= i_cfg_wdata;
            end else begin
                r_save_limit <= i_cfg_wdata[7:0];
            end
        end
    end

    // Decode one request and compute next state and response
    always_comb begin
        set_port       = i_in_data.data[3:0];
        set_bit        = (set_port != 4'd0) ?
                         rmcc_pkg::port_bit({4'd0, set_port} - 8'd1) : 8'd0;
        toggle_bit     = (i_in_data.data != 8'd0) ?
                         rmcc_pkg::port_bit(i_in_data.data - 8'd1) : 8'd0;
        n_mask         = r_mask;
        n_save_pending = r_save_pending;
        n_irq          = r_irq;
        n_rsp          = '0;
        unique case (rmcc_pkg::t_op'(i_in_data.operation))
            rmcc_pkg::OP_WRITE: begin
                unique case (i_in_data.command)
                    rmcc_pkg::CMD_SET_PORT: begin
                        if (i_in_data.data[7:4] != 4'd0) begin
                            n_mask = r_mask | set_bit;
                        end else begin
                            n_mask = r_mask & ~set_bit;
                        end
                    end
                    rmcc_pkg::CMD_TOGGLE_PORT: n_mask = r_mask ^ toggle_bit;
                    rmcc_pkg::CMD_LOAD_MASK:   n_mask = i_in_data.data;
                    rmcc_pkg::CMD_ALL_ON:      n_mask = 8'hFF;
                    rmcc_pkg::CMD_ALL_OFF:     n_mask = 8'h00;
                    default:                   n_mask = r_mask;
                endcase
                n_save_pending    = 1'b1;
                n_rsp.command_led = 1'b1;
            end
            rmcc_pkg::OP_READ: begin
                unique case (i_in_data.command)
                    rmcc_pkg::CMD_GET_PORT: begin
                        n_rsp.read_data = ((r_mask & rmcc_pkg::port_bit(i_in_data.data))
                                           != 8'd0) ? 8'hFF : 8'h00;
                    end
                    rmcc_pkg::CMD_GET_MASK: n_rsp.read_data = r_mask;
                    default:                n_rsp.read_data = 8'h00;
                endcase
                n_irq = 1'b0;
            end
            rmcc_pkg::OP_SWITCH: begin
                n_mask         = r_mask ^ rmcc_pkg::port_bit({5'd0, i_in_data.switch_number});
                n_save_pending = 1'b1;
                n_irq          = 1'b1;
            end
            rmcc_pkg::OP_TICK: begin
                n_rsp.long_reset_request = tick_fire.long_fire;
                if (tick_fire.save_fire) begin
                    n_rsp.save_request = r_save_pending;
                    n_save_pending     = 1'b0;
                end
            end
            default: begin
                n_mask = r_mask;
            end
        endcase
        n_rsp.relay_mask = n_mask;
        n_rsp.irq_line   = n_irq;
    end

    // Advance state on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask         <= 8'd0;
            r_save_pending <= 1'b0;
            r_irq          <= 1'b0;
        end else if (accept) begin
            r_mask         <= n_mask;
            r_save_pending <= n_save_pending;
            r_irq          <= n_irq;
        end
    end

    // Response register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_rsp;
        end
    end

    // Terms watched by the checks below
    assign write_accept  = accept &&
                           (rmcc_pkg::t_op'(i_in_data.operation) == rmcc_pkg::OP_WRITE);
    assign write_rsp_ok  = o_out_valid && o_out_data.command_led &&
                           (o_out_data.read_data == 8'd0);
    assign tick_rsp_ok   = o_out_valid && !o_out_data.command_led &&
                           (o_out_data.read_data == 8'd0);
    assign read_rsp_seen = o_out_valid && (o_out_data.read_data != 8'd0);

`include "relay_mask_command_controller_top_assert.svh"

    `RMCC_ASSERT_NEXT(a_write_lights_led, write_accept, write_rsp_ok, "write must light LED")
    `RMCC_ASSERT_NEXT(a_tick_no_led, tick_accept, tick_rsp_ok, "tick must not light LED")
    `RMCC_ASSERT_SAME(a_read_releases_irq, read_rsp_seen, !o_out_data.irq_line, "read drops irq")

endmodule

`default_nettype wire
